### hw/rtl/tep_pkg.sv
// Shared types, constants and microprogram for the tree ensemble predictor.
`default_nettype none

package tep_pkg;

    // Default sizes of the stores and the depth limit
    localparam int MAX_NODES_DEF    = 1024;
    localparam int MAX_TREES_DEF    = 64;
    localparam int NUM_FEATURES_DEF = 64;
    localparam int MAX_DEPTH_DEF    = 32;

    // Fixed field widths
    localparam int FUNC_W  = 2;
    localparam int SLOT_W  = 10;
    localparam int FEAT_W  = 6;
    localparam int VAL_W   = 32;
    localparam int IDX_W   = 10;
    localparam int SUM_W   = 40;
    localparam int CNT_W   = 7;
    localparam int CIDX_W  = 2;
    localparam int CDATA_W = 7;
    localparam int STEP_W  = 4;

    // Item function codes
    localparam logic [FUNC_W-1:0] FUNC_NODE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ROOT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FEAT = 2'd2;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_FIRST_TREE = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_LAST_TREE  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_EMIT_ALL   = 2'd2;

    // One entry of the node table
    typedef struct packed {
        logic              leaf;
        logic [FEAT_W-1:0] feat;
        logic [VAL_W-1:0]  value;
        logic [IDX_W-1:0]  left;
        logic [IDX_W-1:0]  right;
    } tep_node_t;

    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_INIT,
        UOP_LD_ROOT,
        UOP_STEP,
        UOP_STOP,
        UOP_ADD,
        UOP_EMIT,
        UOP_NEXT,
        UOP_EMPTY
    } tep_uop_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NOT_GO,
        COND_EMPTY,
        COND_BAD_IDX,
        COND_LEAF,
        COND_DEEP,
        COND_LAST
    } tep_cond_t;

    typedef struct packed {
        tep_uop_t          op;
        tep_cond_t         cond;
        logic [STEP_W-1:0] target;
    } tep_uword_t;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic go;
        logic empty;
        logic bad_idx;
        logic leaf;
        logic deep;
        logic last_tree;
    } tep_flags_t;

    // Program step addresses
    localparam logic [STEP_W-1:0] S_IDLE    = 4'd0;
    localparam logic [STEP_W-1:0] S_INIT    = 4'd1;
    localparam logic [STEP_W-1:0] S_ROOT    = 4'd2;
    localparam logic [STEP_W-1:0] S_LD_ROOT = 4'd3;
    localparam logic [STEP_W-1:0] S_CHK     = 4'd4;
    localparam logic [STEP_W-1:0] S_NODE    = 4'd5;
    localparam logic [STEP_W-1:0] S_DEPTH   = 4'd6;
    localparam logic [STEP_W-1:0] S_CMP     = 4'd7;
    localparam logic [STEP_W-1:0] S_STOP    = 4'd8;
    localparam logic [STEP_W-1:0] S_ADD     = 4'd9;
    localparam logic [STEP_W-1:0] S_EMIT    = 4'd10;
    localparam logic [STEP_W-1:0] S_NEXT    = 4'd11;
    localparam logic [STEP_W-1:0] S_EMPTY   = 4'd12;

    // Control store: jump to target when the condition holds, else advance
    function automatic tep_uword_t ucode(input logic [STEP_W-1:0] step);
        tep_uword_t w;
        case (step)
            S_IDLE:    w = '{op: UOP_NOP,     cond: COND_NOT_GO,  target: S_IDLE};
            S_INIT:    w = '{op: UOP_INIT,    cond: COND_EMPTY,   target: S_EMPTY};
            S_ROOT:    w = '{op: UOP_NOP,     cond: COND_NEVER,   target: S_IDLE};
            S_LD_ROOT: w = '{op: UOP_LD_ROOT, cond: COND_NEVER,   target: S_IDLE};
            S_CHK:     w = '{op: UOP_NOP,     cond: COND_BAD_IDX, target: S_STOP};
            S_NODE:    w = '{op: UOP_NOP,     cond: COND_LEAF,    target: S_ADD};
            S_DEPTH:   w = '{op: UOP_NOP,     cond: COND_DEEP,    target: S_STOP};
            S_CMP:     w = '{op: UOP_STEP,    cond: COND_ALWAYS,  target: S_CHK};
            S_STOP:    w = '{op: UOP_STOP,    cond: COND_ALWAYS,  target: S_EMIT};
            S_ADD:     w = '{op: UOP_ADD,     cond: COND_NEVER,   target: S_IDLE};
            S_EMIT:    w = '{op: UOP_EMIT,    cond: COND_LAST,    target: S_IDLE};
            S_NEXT:    w = '{op: UOP_NEXT,    cond: COND_ALWAYS,  target: S_ROOT};
            S_EMPTY:   w = '{op: UOP_EMPTY,   cond: COND_ALWAYS,  target: S_IDLE};
            default:   w = '{op: UOP_NOP,     cond: COND_ALWAYS,  target: S_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/tep_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tep_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### hw/rtl/tep_seq.sv
// Microcode sequencer: step counter, control store and conditional jumps.
`default_nettype none

module tep_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  tep_pkg::tep_flags_t flags,
    output tep_pkg::tep_uword_t uword,
    output logic                idle
);

    import tep_pkg::*;

    logic [STEP_W-1:0] pc_reg;
    logic [STEP_W-1:0] pc_next;
    tep_uword_t        w;
    logic              take;

    always_comb
    begin
        w = ucode(pc_reg);
        case (w.cond)
            COND_NEVER:   take = 1'b0;
            COND_ALWAYS:  take = 1'b1;
            COND_NOT_GO:  take = !flags.go;
            COND_EMPTY:   take = flags.empty;
            COND_BAD_IDX: take = flags.bad_idx;
            COND_LEAF:    take = flags.leaf;
            COND_DEEP:    take = flags.deep;
            COND_LAST:    take = flags.last_tree;
            default:      take = 1'b1;
        endcase
        pc_next = take ? w.target : pc_reg + STEP_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= S_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign uword = w;
    assign idle  = (pc_reg == S_IDLE);

endmodule

`default_nettype wire

### hw/rtl/tree_ensemble_predictor.sv
// Top level: item decode, table memories and the tree walking datapath.
//
// Usage. Items arrive on start/busy: an item is taken at an edge where start is high
// and busy is low. func selects a node table write, a tree root write or a feature
// value; writes never raise busy. A feature item with last_feature set starts
// evaluation: busy rises on the next cycle and stays high until the final result.
// Trees first_tree..last_tree are walked in order by a microcoded sequencer. Each
// walk runs ROOT, LD_ROOT, then CHK, NODE per node and DEPTH, CMP per split node (one
// node table read and one feature read per split node, both through registered-read
// RAMs), then ADD, EMIT and NEXT; INIT runs once first. A walk stopped at the depth
// limit or a bad node index goes to STOP instead of ADD, and the final tree skips
// NEXT. Results appear on prediction/trees_used/last/depth_error for exactly one
// cycle with result_strobe high, after each tree when emit_all is set, or only after
// the final tree. The receiver cannot stall; results are never held. An empty tree
// range gives one result via INIT and EMPTY. Configuration goes over cfg_valid/
// cfg_ready (always ready); the user must configure only while idle, which the block
// does not enforce. Reset sets first_tree 1, last_tree 64, emit_all 0 and idles the
// sequencer; the node, root and feature tables are undefined until written.
`default_nettype none

module tree_ensemble_predictor #(
    parameter int MAX_NODES    = tep_pkg::MAX_NODES_DEF,
    parameter int MAX_TREES    = tep_pkg::MAX_TREES_DEF,
    parameter int NUM_FEATURES = tep_pkg::NUM_FEATURES_DEF,
    parameter int MAX_DEPTH    = tep_pkg::MAX_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [tep_pkg::FUNC_W-1:0]    func,
    input  logic [tep_pkg::SLOT_W-1:0]    slot,
    input  logic                          leaf_flag,
    input  logic [tep_pkg::FEAT_W-1:0]    split_feature,
    input  logic signed [tep_pkg::VAL_W-1:0] value,
    input  logic [tep_pkg::IDX_W-1:0]     left_node,
    input  logic [tep_pkg::IDX_W-1:0]     right_node,
    input  logic [tep_pkg::IDX_W-1:0]     root_node,
    input  logic                          last_feature,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tep_pkg::CIDX_W-1:0]    cfg_index,
    input  logic [tep_pkg::CDATA_W-1:0]   cfg_data,
    output logic                          result_strobe,
    output logic signed [tep_pkg::SUM_W-1:0] prediction,
    output logic [tep_pkg::CNT_W-1:0]     trees_used,
    output logic                          last,
    output logic                          depth_error
);

    import tep_pkg::*;

    localparam int NODE_AW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int TREE_AW  = (MAX_TREES > 1) ? $clog2(MAX_TREES) : 1;
    localparam int FEAT_AW  = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
    localparam int DEPTH_W  = $clog2(MAX_DEPTH + 1);
    localparam int NODE_BITS = $bits(tep_node_t);

    // Configuration registers
    logic [CNT_W-1:0] first_tree_reg;
    logic [CNT_W-1:0] last_tree_reg;
    logic             emit_all_reg;

    // Datapath registers
    logic [CNT_W-1:0]        tree_reg,    tree_next;
    logic [CNT_W-1:0]        hi_reg,      hi_next;
    logic [IDX_W-1:0]        idx_reg,     idx_next;
    logic [DEPTH_W-1:0]      crossed_reg, crossed_next;
    logic signed [SUM_W-1:0] sum_reg,     sum_next;
    logic [CNT_W-1:0]        used_reg,    used_next;
    logic                    err_reg,     err_next;

    // Result registers
    logic                    strobe_reg,  strobe_next;
    logic signed [SUM_W-1:0] pred_reg,    pred_next;
    logic [CNT_W-1:0]        used_o_reg,  used_o_next;
    logic                    final_reg,   final_next;
    logic                    err_o_reg,   err_o_next;

    logic       accept;
    logic       node_we;
    logic       root_we;
    logic       feat_we;
    tep_node_t  node_wdata;
    tep_node_t  node_rd;
    logic [NODE_BITS-1:0] node_rdata;
    logic [IDX_W-1:0]     root_rdata;
    logic [VAL_W-1:0]     feat_rdata;
    logic [CNT_W-1:0]     lo_val;
    logic [CNT_W-1:0]     hi_val;
    logic signed [VAL_W-1:0] fv;
    logic       is_last_tree;

    tep_flags_t flags;
    tep_uword_t uword;
    logic       idle;

    assign accept  = start && !busy;
    assign node_we = accept && (func == FUNC_NODE) && (int'(slot) < MAX_NODES);
    assign root_we = accept && (func == FUNC_ROOT) && (int'(slot) < MAX_TREES);
    assign feat_we = accept && (func == FUNC_FEAT) && (int'(slot) < NUM_FEATURES);

    assign node_wdata = '{leaf: leaf_flag, feat: split_feature, value: value,
                          left: left_node, right: right_node};

    tep_ram #(.WIDTH(NODE_BITS), .DEPTH(MAX_NODES)) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (NODE_AW'(slot)),
        .wdata (node_wdata),
        .raddr (NODE_AW'(idx_reg)),
        .rdata (node_rdata)
    );

    tep_ram #(.WIDTH(IDX_W), .DEPTH(MAX_TREES)) u_root_ram (
        .clk   (clk),
        .we    (root_we),
        .waddr (TREE_AW'(slot)),
        .wdata (root_node),
        .raddr (TREE_AW'(tree_reg - CNT_W'(1))),
        .rdata (root_rdata)
    );

    assign node_rd = node_rdata;

    tep_ram #(.WIDTH(VAL_W), .DEPTH(NUM_FEATURES)) u_feat_ram (
        .clk   (clk),
        .we    (feat_we),
        .waddr (FEAT_AW'(slot)),
        .wdata (value),
        .raddr (FEAT_AW'(node_rd.feat)),
        .rdata (feat_rdata)
    );

    // Clamp the tree range
    assign lo_val = (first_tree_reg == '0) ? CNT_W'(1) : first_tree_reg;
    assign hi_val = (int'(last_tree_reg) > MAX_TREES) ? CNT_W'(MAX_TREES) : last_tree_reg;
    assign is_last_tree = (tree_reg == hi_reg);

    // A feature index beyond the store reads as zero
    assign fv = (int'(node_rd.feat) < NUM_FEATURES) ? signed'(feat_rdata) : '0;

    assign flags = '{go:        accept && (func == FUNC_FEAT) && last_feature,
                     empty:     lo_val > hi_val,
                     bad_idx:   int'(idx_reg) >= MAX_NODES,
                     leaf:      node_rd.leaf,
                     deep:      crossed_reg >= DEPTH_W'(MAX_DEPTH),
                     last_tree: is_last_tree};

    tep_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .uword (uword),
        .idle  (idle)
    );

    always_comb
    begin
        tree_next    = tree_reg;
        hi_next      = hi_reg;
        idx_next     = idx_reg;
        crossed_next = crossed_reg;
        sum_next     = sum_reg;
        used_next    = used_reg;
        err_next     = err_reg;
        strobe_next  = 1'b0;
        pred_next    = pred_reg;
        used_o_next  = used_o_reg;
        final_next   = final_reg;
        err_o_next   = err_o_reg;
        case (uword.op)
            UOP_INIT:
            begin
                tree_next = lo_val;
                hi_next   = hi_val;
                sum_next  = '0;
                used_next = '0;
                err_next  = 1'b0;
            end
            UOP_LD_ROOT:
            begin
                idx_next     = root_rdata;
                crossed_next = '0;
            end
            UOP_STEP:
            begin
                idx_next     = (fv <= signed'(node_rd.value)) ? node_rd.left : node_rd.right;
                crossed_next = crossed_reg + DEPTH_W'(1);
            end
            UOP_STOP:
            begin
                err_next  = 1'b1;
                used_next = used_reg + CNT_W'(1);
            end
            UOP_ADD:
            begin
                sum_next  = sum_reg + SUM_W'(signed'(node_rd.value));
                used_next = used_reg + CNT_W'(1);
            end
            UOP_EMIT:
            begin
                strobe_next = emit_all_reg || is_last_tree;
                pred_next   = sum_reg;
                used_o_next = used_reg;
                final_next  = is_last_tree;
                err_o_next  = err_reg;
            end
            UOP_NEXT:
            begin
                tree_next = tree_reg + CNT_W'(1);
            end
            UOP_EMPTY:
            begin
                strobe_next = 1'b1;
                pred_next   = '0;
                used_o_next = '0;
                final_next  = 1'b1;
                err_o_next  = 1'b0;
            end
            default:
            begin
                strobe_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        tree_reg    <= tree_next;
        hi_reg      <= hi_next;
        idx_reg     <= idx_next;
        crossed_reg <= crossed_next;
        sum_reg     <= sum_next;
        used_reg    <= used_next;
        err_reg     <= err_next;
        pred_reg    <= pred_next;
        used_o_reg  <= used_o_next;
        final_reg   <= final_next;
        err_o_reg   <= err_o_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg     <= 1'b0;
            first_tree_reg <= CNT_W'(1);
            last_tree_reg  <= CNT_W'(64);
            emit_all_reg   <= 1'b0;
        end
        else
        begin
            strobe_reg <= strobe_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_FIRST_TREE: first_tree_reg <= cfg_data;
                    CFG_LAST_TREE:  last_tree_reg  <= cfg_data;
                    CFG_EMIT_ALL:   emit_all_reg   <= cfg_data[0];
                    default:        emit_all_reg   <= emit_all_reg;
                endcase
            end
        end
    end

    assign busy          = !idle;
    assign cfg_ready     = 1'b1;
    assign result_strobe = strobe_reg;
    assign prediction    = pred_reg;
    assign trees_used    = used_o_reg;
    assign last          = final_reg;
    assign depth_error   = err_o_reg;

endmodule

`default_nettype wire

### hw/rtl/tep_checker.sv
// Port-level assertions for the tree ensemble predictor, bound to the top level.
`default_nettype none

module tep_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic [tep_pkg::FUNC_W-1:0]    func,
    input wire logic                          last_feature,
    input wire logic                          result_strobe,
    input wire logic signed [tep_pkg::SUM_W-1:0] prediction,
    input wire logic [tep_pkg::CNT_W-1:0]     trees_used,
    input wire logic                          last,
    input wire logic                          depth_error
);

    import tep_pkg::*;

    // An evaluation transaction must raise busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (func == FUNC_FEAT) && last_feature |=> busy)
        else $error("evaluation start did not raise busy");

    // More trees pending after a partial result
    a_partial_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !last |-> busy)
        else $error("partial result while idle");

    // The final result releases the block
    a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && last |-> !busy)
        else $error("final result while still busy");

    // Results are never back to back
    a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |=> !result_strobe)
        else $error("results on consecutive cycles");

    // A result with no trees is the empty-range result
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && (trees_used == '0) |-> last && (prediction == '0) && !depth_error)
        else $error("bad empty-range result");

endmodule

bind tree_ensemble_predictor tep_checker u_tep_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .func          (func),
    .last_feature  (last_feature),
    .result_strobe (result_strobe),
    .prediction    (prediction),
    .trees_used    (trees_used),
    .last          (last),
    .depth_error   (depth_error)
);

`default_nettype wire
